// File: src/irac_pkg.sv
// Shared types, frame constants and settings checks for the IR AC frame transmitter.
package irac_pkg;

	localparam int unsigned REG_W     = 16;
	localparam int unsigned IN_DATA_W = 48;
	localparam int unsigned OUT_DATA_W = 8;
	localparam int unsigned FRAME_W   = 128;
	localparam int unsigned BITPOS_W  = 7;

	localparam logic [REG_W-1:0] HDR_MARK_RST  = 16'd3270;
	localparam logic [REG_W-1:0] HDR_SPACE_RST = 16'd1630;
	localparam logic [REG_W-1:0] SHORT_RST     = 16'd411;
	localparam logic [REG_W-1:0] LONG_RST      = 16'd1241;

	typedef enum logic [1:0] {
		REG_HDR_MARK  = 2'd0,
		REG_HDR_SPACE = 2'd1,
		REG_SHORT     = 2'd2,
		REG_LONG      = 2'd3
	} reg_idx_t;

	localparam logic [7:0] PREFIX_BYTES [8] = '{
		8'b0001_0100, 8'b0110_0011, 8'h00, 8'h10,
		8'h10, 8'b1111_1110, 8'b0000_1001, 8'b0011_0001
	};
	localparam logic [7:0] CMD_CODES [4] = '{8'h02, 8'b0110_1100, 8'h09, 8'h39};
	localparam logic [7:0] FILL_BYTE   = 8'b0010_0000;
	localparam logic [7:0] CSUM_BASE   = 8'd158;

	localparam logic [BITPOS_W-1:0] LAST_BIT_SHORT = 7'd55;
	localparam logic [BITPOS_W-1:0] LAST_BIT_LONG  = 7'd127;

	localparam logic [5:0] TEMP_MIN = 6'd20;
	localparam logic [5:0] TEMP_MAX = 6'd44;
	localparam logic [2:0] CODE_MAX = 3'd4;

	typedef enum logic [2:0] {
		TMR_NONE   = 3'd0,
		TMR_SLEEP  = 3'd1,
		TMR_OFF    = 3'd2,
		TMR_ON     = 3'd3,
		TMR_ON_OFF = 3'd4
	} timer_kind_t;

	typedef struct packed {
		logic        start_req;
		logic        long_frame;
		logic [1:0]  command;
		logic [5:0]  temperature;
		logic        power_on;
		logic [2:0]  timer_kind;
		logic [2:0]  run_mode;
		logic        swing;
		logic [2:0]  fan_level;
		logic        off_flag;
		logic [10:0] off_minutes;
		logic [11:0] on_minutes;
	} in_fields_t;

	typedef struct packed {
		logic               ok;
		logic [FRAME_W-1:0] bits;
	} frame_build_t;

	function automatic logic [7:0] fixed_sum();
		logic [7:0] s;
		s = FILL_BYTE;
		for (int i = 0; i < 8; i++) s = s + PREFIX_BYTES[i];
		return s;
	endfunction

	localparam logic [7:0] FIXED_SUM = fixed_sum();

	function automatic logic sleep_ok(input logic [11:0] v);
		return v == 12'd30 || v == 12'd60 || v == 12'd120 || v == 12'd180 ||
			v == 12'd300 || v == 12'd420 || v == 12'd540;
	endfunction

	// multiple of 30 up to 600, or of 60 up to 720
	function automatic logic onoff_ok(input logic [11:0] v);
		logic ok;
		ok = 1'b0;
		for (int k = 0; k <= 24; k++) begin
			if (v == 12'(30 * k) && (k <= 20 || k[0] == 1'b0)) ok = 1'b1;
		end
		return ok;
	endfunction

endpackage

// File: src/ir_ac_tx_frame.sv
// Frame builder: settings check, byte packing and checksum for one start request.
module ir_ac_tx_frame (
	input  irac_pkg::in_fields_t   fields,
	output irac_pkg::frame_build_t build
);
	import irac_pkg::*;

	logic [11:0] off_w;
	logic [11:0] on_w;
	logic        range_ok;
	logic        timer_ok;
	logic [7:0]  b8, b9, b10, b11, b12, b13, b15, cmd;
	logic [7:0]  var_sum;

	assign off_w = {1'b0, fields.off_minutes};
	assign on_w  = fields.on_minutes;

	assign range_ok = fields.temperature >= TEMP_MIN && fields.temperature <= TEMP_MAX &&
		fields.timer_kind <= CODE_MAX && fields.run_mode <= CODE_MAX &&
		fields.fan_level <= CODE_MAX;

	always_comb begin
		timer_ok = 1'b0;
		unique case (timer_kind_t'(fields.timer_kind))
			TMR_NONE:   timer_ok = on_w == '0 && off_w == '0;
			TMR_SLEEP:  timer_ok = fields.off_flag && on_w == '0 && sleep_ok(off_w);
			TMR_OFF:    timer_ok = !fields.off_flag && on_w == '0 && onoff_ok(off_w);
			TMR_ON:     timer_ok = off_w == '0 && !fields.off_flag && onoff_ok(on_w);
			TMR_ON_OFF: timer_ok = off_w != '0 && on_w != '0 && onoff_ok(off_w) &&
				onoff_ok(on_w);
			default:    timer_ok = 1'b0;
		endcase
	end

	assign b8  = {fields.temperature, 1'b0, fields.power_on};
	assign b9  = {1'b0, fields.timer_kind, 1'b0, fields.run_mode};
	assign b10 = {3'b000, fields.swing, 1'b0, fields.fan_level};
	assign b11 = fields.off_minutes[7:0];
	assign b12 = {fields.on_minutes[3:0], fields.off_flag, fields.off_minutes[10:8]};
	assign b13 = fields.on_minutes[11:4];
	assign var_sum = b8 + b9 + b10 + b11 + b12 + b13;
	assign b15 = CSUM_BASE - FIXED_SUM - var_sum;
	assign cmd = CMD_CODES[fields.command];

	always_comb begin
		build.ok = range_ok && timer_ok;
		if (fields.long_frame) begin
			build.bits = {b15, FILL_BYTE, b13, b12, b11, b10, b9, b8,
				PREFIX_BYTES[7], PREFIX_BYTES[6], PREFIX_BYTES[5], PREFIX_BYTES[4],
				PREFIX_BYTES[3], PREFIX_BYTES[2], PREFIX_BYTES[1], PREFIX_BYTES[0]};
		end else begin
			build.bits = {72'd0, ~cmd, cmd,
				PREFIX_BYTES[4], PREFIX_BYTES[3], PREFIX_BYTES[2],
				PREFIX_BYTES[1], PREFIX_BYTES[0]};
		end
	end

endmodule

// File: src/ir_ac_frame_transmitter_core.sv
// Top level: tick stream in, per-tick mark/status words out, APB timing registers.
//
//  channel | direction | handshake               | payload
//  s_*     | in        | s_tvalid / s_tready     | tick word: start, kind, settings
//  m_*     | out       | m_tvalid / m_tready     | mark, busy_res, rejected; frame_done on tlast
//  apb     | in        | psel, penable, pready=1 | four 16-bit timing registers
//
// One word per cycle sustained unless m_tready stalls; each word passes the input register, then the result register.
// Frame building, settings check and the segment counter sit in one stage.
// arst_n clears control state and loads the timing reset values.
// A stall on m_tready holds the result register; s_tready drops only when both
// stages are full.
module ir_ac_frame_transmitter_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// command[1:0], temperature[7:2], power_on[8], timer_kind[11:9], run_mode[14:12],
	// swing[15], fan_level[18:16], off_flag[19], off_minutes[30:20], on_minutes[42:31]
	input  logic [irac_pkg::IN_DATA_W-1:0]     s_tdata,
	// start_req[0], long_frame[1]
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// mark[0], busy_res[1], rejected[2]
	output logic [irac_pkg::OUT_DATA_W-1:0]    m_tdata,
	// frame_done
	output logic                               m_tlast,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [3:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import irac_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE   = 3'd0,
		PH_HMARK  = 3'd1,
		PH_HSPACE = 3'd2,
		PH_BMARK  = 3'd3,
		PH_BSPACE = 3'd4,
		PH_TRAIL  = 3'd5
	} phase_t;

	logic [REG_W-1:0] hdr_mark_q, hdr_space_q, short_q, long_q;

	logic                 in_valid_s1;
	logic [IN_DATA_W-1:0] in_data_s1;
	logic [1:0]           in_user_s1;

	phase_t              phase_q;
	logic [REG_W-1:0]    tick_q;
	logic [BITPOS_W-1:0] bitpos_q;
	logic                is_long_q;
	logic [FRAME_W-1:0]  frame_q;

	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;
	logic                  out_last_q;

	in_fields_t   fields;
	frame_build_t build;
	logic         adv;
	logic         start, start_ok, rej;
	phase_t       ph_e, phase_d;
	logic [REG_W-1:0]    tick_e, tick_d, seg_len;
	logic [BITPOS_W-1:0] bp_e, bp_d, last_bit;
	logic [REG_W:0]      cnt;
	logic         seg_end, active, mark, done;
	logic         cfg_wr;

	// configuration
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_mark_q  <= HDR_MARK_RST;
			hdr_space_q <= HDR_SPACE_RST;
			short_q     <= SHORT_RST;
			long_q      <= LONG_RST;
		end else if (cfg_wr) begin
			unique case (reg_idx_t'(paddr[3:2]))
				REG_HDR_MARK:  hdr_mark_q  <= pwdata[REG_W-1:0];
				REG_HDR_SPACE: hdr_space_q <= pwdata[REG_W-1:0];
				REG_SHORT:     short_q     <= pwdata[REG_W-1:0];
				REG_LONG:      long_q      <= pwdata[REG_W-1:0];
				default:       ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx_t'(paddr[3:2]))
			REG_HDR_MARK:  prdata = {16'd0, hdr_mark_q};
			REG_HDR_SPACE: prdata = {16'd0, hdr_space_q};
			REG_SHORT:     prdata = {16'd0, short_q};
			REG_LONG:      prdata = {16'd0, long_q};
			default:       prdata = '0;
		endcase
	end

	// input register
	assign adv      = in_valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !in_valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			in_data_s1 <= s_tdata;
			in_user_s1 <= s_tuser;
		end
	end

	always_comb begin
		fields.start_req   = in_user_s1[0];
		fields.long_frame  = in_user_s1[1];
		fields.command     = in_data_s1[1:0];
		fields.temperature = in_data_s1[7:2];
		fields.power_on    = in_data_s1[8];
		fields.timer_kind  = in_data_s1[11:9];
		fields.run_mode    = in_data_s1[14:12];
		fields.swing       = in_data_s1[15];
		fields.fan_level   = in_data_s1[18:16];
		fields.off_flag    = in_data_s1[19];
		fields.off_minutes = in_data_s1[30:20];
		fields.on_minutes  = in_data_s1[42:31];
	end

	ir_ac_tx_frame u_frame (
		.fields (fields),
		.build  (build)
	);

	// tick step
	assign start    = fields.start_req;
	assign start_ok = start && phase_q == PH_IDLE && (!fields.long_frame || build.ok);
	assign rej      = start && !start_ok;
	assign ph_e     = start_ok ? PH_HMARK : phase_q;
	assign tick_e   = start_ok ? '0 : tick_q;
	assign bp_e     = start_ok ? '0 : bitpos_q;
	assign last_bit = is_long_q ? LAST_BIT_LONG : LAST_BIT_SHORT;

	always_comb begin
		unique case (ph_e)
			PH_HMARK:  seg_len = hdr_mark_q;
			PH_HSPACE: seg_len = hdr_space_q;
			PH_BSPACE: seg_len = frame_q[bp_e] ? long_q : short_q;
			default:   seg_len = short_q;
		endcase
	end

	// a zero length acts as one since cnt starts at one
	assign cnt     = {1'b0, tick_e} + 17'd1;
	assign seg_end = cnt >= {1'b0, seg_len};
	assign active  = ph_e != PH_IDLE;

	always_comb begin
		phase_d = ph_e;
		bp_d    = bp_e;
		tick_d  = tick_e;
		mark    = 1'b0;
		done    = 1'b0;
		if (active) begin
			mark   = ph_e == PH_HMARK || ph_e == PH_BMARK || ph_e == PH_TRAIL;
			tick_d = seg_end ? '0 : cnt[REG_W-1:0];
			if (seg_end) begin
				unique case (ph_e)
					PH_HMARK:  phase_d = PH_HSPACE;
					PH_HSPACE: begin
						phase_d = PH_BMARK;
						bp_d    = '0;
					end
					PH_BMARK:  phase_d = PH_BSPACE;
					PH_BSPACE: begin
						if (bp_e >= last_bit) begin
							phase_d = PH_TRAIL;
						end else begin
							phase_d = PH_BMARK;
							bp_d    = bp_e + 7'd1;
						end
					end
					default: begin
						phase_d = PH_IDLE;
						bp_d    = '0;
						done    = 1'b1;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			tick_q    <= '0;
			bitpos_q  <= '0;
			is_long_q <= 1'b0;
		end else if (adv) begin
			phase_q  <= phase_d;
			tick_q   <= tick_d;
			bitpos_q <= bp_d;
			if (start_ok) is_long_q <= fields.long_frame;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && start_ok) frame_q <= build.bits;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {5'd0, rej, active, mark};
			out_last_q <= done;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_idle_clean: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == PH_IDLE |-> tick_q == '0 && bitpos_q == '0)
		else $error("idle with stale counters");

	a_short_bits: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q != PH_IDLE && !is_long_q |-> bitpos_q <= LAST_BIT_SHORT)
		else $error("short frame ran past its last bit");

	a_busy_reject: assert property (@(posedge clk) disable iff (!arst_n)
		adv && start && phase_q != PH_IDLE |=> out_valid_q && out_data_q[2])
		else $error("start while busy not rejected");

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_data_q[1] && out_data_q[0])
		else $error("frame_done outside a trailing mark");
`endif

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for ir_ac_frame_transmitter_core: tick stream, APB timing, frame waveform.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import irac_pkg::*;

	localparam int LIMIT_CYCLES = 100000;

	localparam logic [7:0] HEAD_BYTES [8] = '{8'h14, 8'h63, 8'h00, 8'h10, 8'h10, 8'hFE, 8'h09, 8'h31};
	localparam logic [7:0] CMD_BYTES [4] = '{8'h02, 8'h6C, 8'h09, 8'h39};
	localparam logic [7:0] TAIL_FILL = 8'h20;
	localparam logic [7:0] SUM_BASE  = 8'd158;
	localparam logic [6:0] END_BIT_SHORT = 7'd55;
	localparam logic [6:0] END_BIT_LONG  = 7'd127;
	localparam int TEMP_LO  = 20;
	localparam int TEMP_HI  = 44;
	localparam int CODE_TOP = 4;
	localparam int SLEEP_SET [7] = '{30, 60, 120, 180, 300, 420, 540};

	typedef enum logic [2:0] {
		SEG_IDLE, SEG_HDR_MARK, SEG_HDR_SPACE, SEG_BIT_MARK, SEG_BIT_SPACE, SEG_TRAILER
	} seg_t;

	typedef struct packed {
		logic rejected;
		logic frame_done;
		logic busy;
		logic mark;
	} tick_word_t;

	class ir_tick_scoreboard;
		logic [15:0] tick_len [4];
		logic [7:0]  frame_bytes [16];
		logic [6:0]  bit_pos;
		logic [15:0] seg_cnt;
		logic        is_long;
		seg_t        seg;
		tick_word_t  due_words [$];
		int          errors;
		int          reported;
		int          words_seen;

		function new();
			tick_len[REG_HDR_MARK]  = 16'd3270;
			tick_len[REG_HDR_SPACE] = 16'd1630;
			tick_len[REG_SHORT]     = 16'd411;
			tick_len[REG_LONG]      = 16'd1241;
			bit_pos = '0;
			seg_cnt = '0;
			is_long = 1'b0;
			seg = SEG_IDLE;
			errors = 0;
			reported = 0;
			words_seen = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [15:0] v);
			tick_len[idx] = v;
		endfunction

		function bit timer_ok(int unsigned v);
			return (v <= 600 && v % 30 == 0) || (v <= 720 && v % 60 == 0);
		endfunction

		function bit sleep_ok(int unsigned v);
			foreach (SLEEP_SET[i]) if (v == SLEEP_SET[i]) return 1'b1;
			return 1'b0;
		endfunction

		function bit settings_valid(in_fields_t f);
			int unsigned off_m;
			int unsigned on_m;
			off_m = f.off_minutes;
			on_m = f.on_minutes;
			if (f.temperature < TEMP_LO || f.temperature > TEMP_HI || f.timer_kind > CODE_TOP ||
				f.run_mode > CODE_TOP || f.fan_level > CODE_TOP)
				return 1'b0;
			case (f.timer_kind)
				TMR_NONE:  return on_m == 0 && off_m == 0;
				TMR_SLEEP: return f.off_flag && on_m == 0 && sleep_ok(off_m);
				TMR_OFF:   return !f.off_flag && on_m == 0 && timer_ok(off_m);
				TMR_ON:    return off_m == 0 && !f.off_flag && timer_ok(on_m);
				default:   return off_m != 0 && on_m != 0 && timer_ok(off_m) && timer_ok(on_m);
			endcase
		endfunction

		function void latch(in_fields_t f);
			logic [7:0] sum;
			if (!f.long_frame) begin
				for (int i = 0; i < 5; i++) frame_bytes[i] = HEAD_BYTES[i];
				frame_bytes[5] = CMD_BYTES[f.command];
				frame_bytes[6] = ~CMD_BYTES[f.command];
				is_long = 1'b0;
				return;
			end
			for (int i = 0; i < 8; i++) frame_bytes[i] = HEAD_BYTES[i];
			frame_bytes[8]  = {f.temperature, 1'b0, f.power_on};
			frame_bytes[9]  = {1'b0, f.timer_kind, 1'b0, f.run_mode};
			frame_bytes[10] = {3'b000, f.swing, 1'b0, f.fan_level};
			frame_bytes[11] = f.off_minutes[7:0];
			frame_bytes[12] = {f.on_minutes[3:0], f.off_flag, f.off_minutes[10:8]};
			frame_bytes[13] = f.on_minutes[11:4];
			frame_bytes[14] = TAIL_FILL;
			sum = '0;
			for (int i = 0; i < 15; i++) sum = sum + frame_bytes[i];
			frame_bytes[15] = SUM_BASE - sum;
			is_long = 1'b1;
		endfunction

		// zero-length register acts as one tick
		function int unsigned seg_len();
			logic [15:0] len;
			case (seg)
				SEG_HDR_MARK:  len = tick_len[REG_HDR_MARK];
				SEG_HDR_SPACE: len = tick_len[REG_HDR_SPACE];
				SEG_BIT_SPACE: len = frame_bytes[bit_pos[6:3]][bit_pos[2:0]] ?
					tick_len[REG_LONG] : tick_len[REG_SHORT];
				default:       len = tick_len[REG_SHORT];
			endcase
			return (len == 0) ? 1 : len;
		endfunction

		function bit idle();
			return seg == SEG_IDLE;
		endfunction

		function bit ends_next();
			return seg == SEG_TRAILER && seg_cnt + 1 >= seg_len();
		endfunction

		function int pending();
			return due_words.size();
		endfunction

		function void note_tick(in_fields_t f);
			tick_word_t w;
			w = '0;
			if (f.start_req) begin
				if (seg != SEG_IDLE || (f.long_frame && !settings_valid(f))) begin
					w.rejected = 1'b1;
				end else begin
					latch(f);
					seg = SEG_HDR_MARK;
					seg_cnt = '0;
					bit_pos = '0;
				end
			end
			if (seg != SEG_IDLE) begin
				w.busy = 1'b1;
				w.mark = seg inside {SEG_HDR_MARK, SEG_BIT_MARK, SEG_TRAILER};
				if (seg_cnt + 1 >= seg_len()) begin
					seg_cnt = '0;
					case (seg)
						SEG_HDR_MARK: seg = SEG_HDR_SPACE;
						SEG_HDR_SPACE: begin
							seg = SEG_BIT_MARK;
							bit_pos = '0;
						end
						SEG_BIT_MARK: seg = SEG_BIT_SPACE;
						SEG_BIT_SPACE: begin
							if (bit_pos >= (is_long ? END_BIT_LONG : END_BIT_SHORT)) begin
								seg = SEG_TRAILER;
							end else begin
								bit_pos = bit_pos + 1;
								seg = SEG_BIT_MARK;
							end
						end
						default: begin
							seg = SEG_IDLE;
							bit_pos = '0;
							w.frame_done = 1'b1;
						end
					endcase
				end else begin
					seg_cnt = seg_cnt + 1;
				end
			end
			due_words.push_back(w);
		endfunction

		function void check_word(logic [7:0] data, logic last);
			tick_word_t got;
			tick_word_t want;
			got.mark       = data[0];
			got.busy       = data[1];
			got.rejected   = data[2];
			got.frame_done = last;
			words_seen++;
			if (due_words.size() == 0) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("word %0d: %b/%b arrived with nothing outstanding",
						words_seen, data, last);
				end
				return;
			end
			want = due_words.pop_front();
			if (got.mark !== want.mark || got.busy !== want.busy ||
				got.frame_done !== want.frame_done || got.rejected !== want.rejected) begin
				errors++;
				if (reported < 10) begin
					reported++;
					$display("word %0d: mark %b/%b busy %b/%b done %b/%b rejected %b/%b (exp/act)",
						words_seen, want.mark, got.mark, want.busy, got.busy,
						want.frame_done, got.frame_done, want.rejected, got.rejected);
				end
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [47:0] s_tdata  = '0;
	logic [1:0]  s_tuser  = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;
	logic        m_tlast;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [3:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int cycles        = 0;

	ir_tick_scoreboard sb = new();

	ir_ac_frame_transmitter_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT_CYCLES) begin
			$display("ir_ac_frame_transmitter_core regression: fail");
			$finish;
		end
	end

	always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

	always @(posedge clk) if (arst_n && m_tvalid && m_tready) sb.check_word(m_tdata, m_tlast);

	function automatic in_fields_t random_fields();
		logic [63:0] r;
		r = {$urandom(), $urandom()};
		return r[$bits(in_fields_t)-1:0];
	endfunction

	function automatic logic [11:0] timer_minutes(bit nonzero);
		if ($urandom_range(1))
			return 12'(30 * $urandom_range(20, int'(nonzero)));
		return 12'(60 * $urandom_range(12, int'(nonzero)));
	endfunction

	function automatic in_fields_t valid_settings(bit long_kind);
		in_fields_t f;
		f = random_fields();
		f.start_req   = 1'b1;
		f.long_frame  = long_kind;
		f.temperature = 6'($urandom_range(TEMP_HI, TEMP_LO));
		f.run_mode    = 3'($urandom_range(CODE_TOP));
		f.fan_level   = 3'($urandom_range(CODE_TOP));
		f.timer_kind  = 3'($urandom_range(CODE_TOP));
		case (f.timer_kind)
			TMR_NONE: begin
				f.off_minutes = '0;
				f.on_minutes  = '0;
			end
			TMR_SLEEP: begin
				f.off_flag    = 1'b1;
				f.on_minutes  = '0;
				f.off_minutes = 11'(SLEEP_SET[$urandom_range(6)]);
			end
			TMR_OFF: begin
				f.off_flag    = 1'b0;
				f.on_minutes  = '0;
				f.off_minutes = 11'(timer_minutes(1'b0));
			end
			TMR_ON: begin
				f.off_flag    = 1'b0;
				f.off_minutes = '0;
				f.on_minutes  = timer_minutes(1'b0);
			end
			default: begin
				f.off_minutes = 11'(timer_minutes(1'b1));
				f.on_minutes  = timer_minutes(1'b1);
			end
		endcase
		return f;
	endfunction

	function automatic in_fields_t spoil_settings(in_fields_t f);
		case ($urandom_range(6))
			0: f.temperature = $urandom_range(1) ? 6'($urandom_range(TEMP_LO - 1)) :
				6'($urandom_range(63, TEMP_HI + 1));
			1: f.timer_kind = 3'($urandom_range(7, CODE_TOP + 1));
			2: f.run_mode = 3'($urandom_range(7, CODE_TOP + 1));
			3: f.fan_level = 3'($urandom_range(7, CODE_TOP + 1));
			4: begin
				f.timer_kind  = TMR_SLEEP;
				f.on_minutes  = '0;
				f.off_flag    = 1'($urandom_range(1));
				f.off_minutes = f.off_flag ? 11'd90 : 11'd30;
			end
			5: begin
				f.timer_kind  = TMR_ON;
				f.off_minutes = '0;
				f.off_flag    = 1'b0;
				f.on_minutes  = $urandom_range(1) ? 12'd630 : 12'd750;
			end
			default: begin
				f.timer_kind  = TMR_ON_OFF;
				f.off_minutes = '0;
				f.on_minutes  = 12'd60;
			end
		endcase
		return f;
	endfunction

	// mostly back-to-back frames; stray starts while busy and on the last trailer tick
	function automatic in_fields_t next_tick();
		in_fields_t f;
		int p;
		f = random_fields();
		p = $urandom_range(99);
		if (sb.idle()) begin
			if (p < 70) f = valid_settings(1'($urandom_range(1)));
			else if (p < 85) f = spoil_settings(valid_settings(1'b1));
			else f.start_req = 1'b0;
		end else if (sb.ends_next()) begin
			f.start_req = (p < 60);
		end else begin
			f.start_req = (p < 4);
		end
		return f;
	endfunction

	function automatic in_fields_t base_long();
		in_fields_t f;
		f = '0;
		f.start_req   = 1'b1;
		f.long_frame  = 1'b1;
		f.temperature = 6'd30;
		f.timer_kind  = TMR_NONE;
		f.run_mode    = 3'd2;
		f.fan_level   = 3'd3;
		return f;
	endfunction

	task automatic send_tick(in_fields_t f);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {f.long_frame, f.start_req};
		s_tdata  <= {5'b0, f.on_minutes, f.off_minutes, f.off_flag, f.fan_level, f.swing,
			f.run_mode, f.timer_kind, f.power_on, f.temperature, f.command};
		do @(posedge clk); while (!s_tready);
		sb.note_tick(f);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		do @(negedge clk); while (sb.pending() != 0);
	endtask

	task automatic apb_write(reg_idx_t idx, logic [15:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= {16'h0000, v};
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		sb.set_reg(idx, v);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(int n, int pause_at);
		for (int i = 0; i < n; i++) begin
			if (i == pause_at) begin
				s_tvalid <= 1'b0;
				wait_drained();
			end
			send_tick(next_tick());
		end
	endtask

	initial begin
		in_fields_t f;
		logic [15:0] cfg [5][4];
		int idle_tab [5];
		int stall_tab [5];
		int len_tab [5];
		int pause_tab [5];

		cfg[0] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
		cfg[1] = '{16'd0, 16'd0, 16'd0, 16'd0};
		cfg[2] = '{16'd1, 16'd0, 16'd1, 16'd2};
		cfg[3] = '{16'd3, 16'd2, 16'd2, 16'd1};
		cfg[4] = '{16'd2, 16'd1, 16'd1, 16'd3};
		idle_tab  = '{0, 0, 76, 0, 13};
		stall_tab = '{0, 0, 0, 76, 13};
		len_tab   = '{30, 160, 160, 160, 160};
		pause_tab = '{-1, -1, 90, -1, -1};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// rejects from idle, then one short frame and starts while busy
		f = '0;
		send_tick(f);
		f = '1;
		f.start_req = 1'b0;
		send_tick(f);
		f = base_long();
		f.temperature = 6'd19;
		send_tick(f);
		f.temperature = 6'd45;
		send_tick(f);
		f = '1;
		send_tick(f);
		f = base_long();
		f.timer_kind = 3'd5;
		send_tick(f);
		f = base_long();
		f.run_mode = 3'd5;
		send_tick(f);
		f = base_long();
		f.fan_level = 3'd5;
		send_tick(f);
		f = base_long();
		f.off_minutes = 11'd30;
		send_tick(f);
		f = base_long();
		f.on_minutes = 12'd60;
		send_tick(f);
		f = base_long();
		f.timer_kind = TMR_SLEEP;
		f.off_minutes = 11'd30;
		send_tick(f);
		f.off_flag = 1'b1;
		f.off_minutes = 11'd90;
		send_tick(f);
		f = base_long();
		f.timer_kind = TMR_OFF;
		f.off_minutes = 11'd630;
		send_tick(f);
		f.off_minutes = 11'd60;
		f.off_flag = 1'b1;
		send_tick(f);
		f = base_long();
		f.timer_kind = TMR_ON;
		f.on_minutes = 12'd780;
		send_tick(f);
		f.on_minutes = 12'd720;
		f.off_minutes = 11'd60;
		send_tick(f);
		f = base_long();
		f.timer_kind = TMR_ON_OFF;
		f.on_minutes = 12'd60;
		send_tick(f);
		f = base_long();
		f.timer_kind = TMR_ON_OFF;
		f.off_minutes = 11'd600;
		send_tick(f);
		f = '1;
		f.long_frame = 1'b0;
		send_tick(f);
		f = base_long();
		f.timer_kind = TMR_ON_OFF;
		f.on_minutes = 12'd720;
		f.off_minutes = 11'd600;
		send_tick(f);
		f = '0;
		f.start_req = 1'b1;
		send_tick(f);
		s_tvalid <= 1'b0;
		wait_drained();

		for (int p = 0; p < 5; p++) begin
			apb_write(REG_HDR_MARK, cfg[p][0]);
			apb_write(REG_HDR_SPACE, cfg[p][1]);
			apb_write(REG_SHORT, cfg[p][2]);
			apb_write(REG_LONG, cfg[p][3]);
			send_idle_pct = idle_tab[p];
			stall_pct = stall_tab[p];
			run_phase(len_tab[p], pause_tab[p]);
			s_tvalid <= 1'b0;
			wait_drained();
		end

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("ir_ac_frame_transmitter_core regression: pass");
		else
			$display("ir_ac_frame_transmitter_core regression: fail");
		$finish;
	end

endmodule
